// ----- rtl/core/fqdp_pkg.sv -----
// ----------------------------------------------------------------------------
// fqdp_pkg
// Shared types and constants of the frame queue with drop policy.
// ----------------------------------------------------------------------------
package fqdp_pkg;

    localparam int FUNC_W   = 2;
    localparam int HWM_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int HANDLE_W = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [FUNC_W-1:0] FUNC_ENQ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    localparam logic REG_HWM = 1'b0;

    localparam logic [HWM_W-1:0] HWM_RESET = 5'd3;

    typedef struct packed {
        logic load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic count_gt_one;
    } t_stat;

endpackage

// ----- rtl/core/frame_queue_drop_policy_unit.sv -----
// ----------------------------------------------------------------------------
// frame_queue_drop_policy_unit
// Ring-buffer queue of frame handles with key-frame aware drop policy.
// ----------------------------------------------------------------------------
// Enqueue, dequeue and the unused function code each give one result; a new
// request is taken alongside the transfer of the previous result out of the
// output register, or once that result has left it. A clear of n held entries
// gives n results (one result when empty), since the ring buffer pops one
// entry per cycle, while the output is not stalled, through its single read
// port; requests stall until the sweep is done. The high-water mark is written
// through the APB port at byte address 0 and should only change while idle.
// ----------------------------------------------------------------------------
module frame_queue_drop_policy_unit
    import fqdp_pkg::*;
#(
    parameter int CAPACITY    = 5,
    parameter int HANDLE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [HANDLE_W-1:0] i_frame_handle,
    input  logic                i_is_key_frame,
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output logic                o_out_valid,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic                o_dropped,
    output logic [HANDLE_W-1:0] o_dropped_handle,
    output logic [COUNT_W-1:0]  o_queue_count,
    output logic                o_last
);

    logic [HWM_W-1:0] w_hwm;
    t_cmd             w_cmd;
    t_stat            w_stat;

    fqdp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_hwm   (w_hwm)
    );

    fqdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fqdp_dpath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_hwm            (w_hwm),
        .i_func           (i_func),
        .i_frame_handle   (i_frame_handle),
        .i_is_key_frame   (i_is_key_frame),
        .o_out_valid      (o_out_valid),
        .o_out_handle     (o_out_handle),
        .o_dropped        (o_dropped),
        .o_dropped_handle (o_dropped_handle),
        .o_queue_count    (o_queue_count),
        .o_last           (o_last)
    );

endmodule

// ----- rtl/core/fqdp_cfg.sv -----
// ----------------------------------------------------------------------------
// fqdp_cfg
// APB register bank holding the high-water mark.
// ----------------------------------------------------------------------------
module fqdp_cfg
    import fqdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [HWM_W-1:0]  o_hwm
);

    logic [HWM_W-1:0] r_hwm;
    logic             w_sel_hwm;

    assign w_sel_hwm = (paddr[2] == REG_HWM);
    assign pready    = 1'b1;
    assign o_hwm     = r_hwm;

    always_comb begin
        prdata = '0;
        if (w_sel_hwm) begin
            prdata = APB_DW'(r_hwm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm <= HWM_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_hwm) begin
            r_hwm <= pwdata[HWM_W-1:0];
        end
    end

endmodule

// ----- rtl/core/fqdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// fqdp_ctrl
// Sequencer for request transfers, clear sweeps and the result register.
// ----------------------------------------------------------------------------
module fqdp_ctrl
    import fqdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_stall,
    output logic  o_rsp_valid,
    input  logic  i_rsp_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_CLEAR
    } t_state;

    t_state r_state;
    logic   r_rsp_valid;
    logic   w_out_free;
    logic   w_accept;
    logic   w_clr_step;

    assign w_out_free = !r_rsp_valid || !i_rsp_stall;
    assign w_accept   = (r_state == ST_IDLE) && w_out_free && i_req_valid;
    assign w_clr_step = (r_state == ST_CLEAR) && w_out_free;

    assign o_req_stall    = !((r_state == ST_IDLE) && w_out_free);
    assign o_rsp_valid    = r_rsp_valid;
    assign o_cmd.load     = w_accept;
    assign o_cmd.clr_step = w_clr_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept || w_clr_step) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_stat.is_clear && i_stat.count_gt_one) begin
                        r_state <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (w_clr_step && !i_stat.count_gt_one) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/fqdp_dpath.sv -----
// ----------------------------------------------------------------------------
// fqdp_dpath
// Ring buffer, drop policy and result payload register.
// ----------------------------------------------------------------------------
module fqdp_dpath
    import fqdp_pkg::*;
#(
    parameter int CAPACITY    = 5,
    parameter int HANDLE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [HWM_W-1:0]    i_hwm,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [HANDLE_W-1:0] i_frame_handle,
    input  logic                i_is_key_frame,
    output logic                o_out_valid,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic                o_dropped,
    output logic [HANDLE_W-1:0] o_dropped_handle,
    output logic [COUNT_W-1:0]  o_queue_count,
    output logic                o_last
);

    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    logic [STORE_W-1:0] r_mem [CAPACITY];
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic               r_dropped_prev;

    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_dropped;
    logic [HANDLE_W-1:0] r_dropped_handle;
    logic [COUNT_W-1:0]  r_queue_count;
    logic                r_last;

    logic [IDX_W-1:0]    n_head;
    logic [IDX_W-1:0]    n_tail;
    logic [CNT_W-1:0]    n_count;
    logic                n_dropped_prev;
    logic                n_out_valid;
    logic [HANDLE_W-1:0] n_out_handle;
    logic                n_dropped;
    logic [HANDLE_W-1:0] n_dropped_handle;
    logic                n_last;

    logic                w_do_push;
    logic                w_do_pop;
    logic                w_rewind;
    logic                w_full;
    logic                w_empty;
    logic [STORE_W-1:0]  w_in_handle;
    logic [HANDLE_W-1:0] w_new_ext;
    logic [HANDLE_W-1:0] w_head_ext;

    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_in_handle = i_frame_handle[STORE_W-1:0];
    assign w_new_ext   = HANDLE_W'(w_in_handle);
    assign w_head_ext  = HANDLE_W'(r_mem[r_head]);

    assign o_stat.is_clear     = (i_func == FUNC_CLEAR);
    assign o_stat.count_gt_one = (r_count > CNT_W'(1));

    always_comb begin
        w_do_push        = 1'b0;
        w_do_pop         = 1'b0;
        w_rewind         = 1'b0;
        n_dropped_prev   = r_dropped_prev;
        n_out_valid      = 1'b0;
        n_out_handle     = '0;
        n_dropped        = 1'b0;
        n_dropped_handle = '0;
        n_last           = 1'b1;
        priority if (i_cmd.clr_step || (i_cmd.load && i_func == FUNC_CLEAR)) begin
            if (!w_empty) begin
                w_do_pop         = 1'b1;
                n_dropped        = 1'b1;
                n_dropped_handle = w_head_ext;
            end
            n_last   = (r_count <= CNT_W'(1));
            w_rewind = (r_count <= CNT_W'(1));
        end else if (i_cmd.load) begin
            unique case (i_func)
                FUNC_ENQ: begin
                    if (i_is_key_frame || HWM_W'(r_count) < i_hwm) begin
                        w_do_pop       = w_full;
                        w_do_push      = 1'b1;
                        n_dropped_prev = 1'b0;
                    end else if (!r_dropped_prev) begin
                        n_dropped        = 1'b1;
                        n_dropped_handle = w_new_ext;
                        n_dropped_prev   = 1'b1;
                    end else begin
                        w_do_pop       = !w_empty;
                        w_do_push      = 1'b1;
                        n_dropped_prev = 1'b0;
                    end
                    if (w_do_pop) begin
                        n_dropped        = 1'b1;
                        n_dropped_handle = w_head_ext;
                    end
                end
                FUNC_DEQ: begin
                    if (!w_empty) begin
                        w_do_pop     = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_handle = w_head_ext;
                    end
                end
                FUNC_CLEAR, FUNC_NOP: begin
                end
                default: begin
                end
            endcase
        end else begin
        end
        n_head  = w_do_pop ? f_inc(r_head) : r_head;
        n_tail  = w_do_push ? f_inc(r_tail) : r_tail;
        n_count = r_count + CNT_W'(w_do_push) - CNT_W'(w_do_pop);
        if (w_rewind) begin
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_dropped_prev <= 1'b0;
        end else begin
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_dropped_prev <= n_dropped_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_tail] <= w_in_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.clr_step) begin
            r_out_valid      <= n_out_valid;
            r_out_handle     <= n_out_handle;
            r_dropped        <= n_dropped;
            r_dropped_handle <= n_dropped_handle;
            r_queue_count    <= COUNT_W'(n_count);
            r_last           <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_handle     = r_out_handle;
    assign o_dropped        = r_dropped;
    assign o_dropped_handle = r_dropped_handle;
    assign o_queue_count    = r_queue_count;
    assign o_last           = r_last;

endmodule

// ----- dv/frame_queue_drop_policy_unit_tb.sv -----
// ----------------------------------------------------------------------------
// frame_queue_drop_policy_unit_tb
// Self-checking bench for the frame queue with drop policy. A directed table
// walks the reset state, empty-queue cases, the alternating drop, key frames
// at a full queue, marks of zero and above capacity and full clear sweeps.
// Random enqueue, dequeue, clear and unused-code traffic follows under
// several high-water marks. Every response transfer is checked field by
// field against an in-bench model of the ring buffer and its drop toggle,
// with random idling on both channels and one long output back-pressure.
// ----------------------------------------------------------------------------
module frame_queue_drop_policy_unit_tb
    import fqdp_pkg::*;
();

    localparam int CAPACITY         = 5;
    localparam int NO_MARK          = -1;
    localparam int RANDOM_PER_PHASE = 26;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD        = 40;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam logic [APB_AW-1:0] MARK_ADDR = APB_AW'(4 * REG_HWM);

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
        logic                key;
    } t_req;

    typedef struct packed {
        logic                out_valid;
        logic [HANDLE_W-1:0] out_handle;
        logic                dropped;
        logic [HANDLE_W-1:0] dropped_handle;
        logic [COUNT_W-1:0]  queue_count;
        logic                last;
    } t_res;

    typedef struct {
        t_req req;
        int   mark;
        bit   typed;
        t_res want;
    } t_plan_row;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_req_valid    = 1'b0;
    logic                o_req_stall;
    logic [FUNC_W-1:0]   i_func         = FUNC_NOP;
    logic [HANDLE_W-1:0] i_frame_handle = '0;
    logic                i_is_key_frame = 1'b0;
    logic                o_rsp_valid;
    logic                i_rsp_stall    = 1'b0;
    logic                o_out_valid;
    logic [HANDLE_W-1:0] o_out_handle;
    logic                o_dropped;
    logic [HANDLE_W-1:0] o_dropped_handle;
    logic [COUNT_W-1:0]  o_queue_count;
    logic                o_last;

    logic [HANDLE_W-1:0] ring_slots [CAPACITY];
    int unsigned         ring_head    = 0;
    int unsigned         ring_tail    = 0;
    int unsigned         ring_count   = 0;
    bit                  drop_toggle  = 1'b0;
    logic [HWM_W-1:0]    mark_reg     = HWM_RESET;

    t_res      awaited_results [$];
    t_plan_row directed_plan [$];
    int        error_count      = 0;
    int        quiet_cycles     = 0;
    int        long_hold_cycles = 0;
    bit        req_idle_on      = 1'b1;
    bit        rsp_idle_on      = 1'b1;

    always #1 i_clk = ~i_clk;

    frame_queue_drop_policy_unit #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_req_valid      (i_req_valid),
        .o_req_stall      (o_req_stall),
        .i_func           (i_func),
        .i_frame_handle   (i_frame_handle),
        .i_is_key_frame   (i_is_key_frame),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_stall      (i_rsp_stall),
        .o_out_valid      (o_out_valid),
        .o_out_handle     (o_out_handle),
        .o_dropped        (o_dropped),
        .o_dropped_handle (o_dropped_handle),
        .o_queue_count    (o_queue_count),
        .o_last           (o_last)
    );

    function automatic t_res make_result(logic ov, logic [HANDLE_W-1:0] oh, logic d,
                                         logic [HANDLE_W-1:0] dh, logic last);
        t_res r;
        r.out_valid      = ov;
        r.out_handle     = oh;
        r.dropped        = d;
        r.dropped_handle = dh;
        r.queue_count    = COUNT_W'(ring_count);
        r.last           = last;
        return r;
    endfunction

    function automatic logic [HANDLE_W-1:0] pop_oldest_slot();
        logic [HANDLE_W-1:0] h;
        h          = ring_slots[ring_head];
        ring_head  = (ring_head + 1) % CAPACITY;
        ring_count = ring_count - 1;
        return h;
    endfunction

    function automatic void push_newest_slot(logic [HANDLE_W-1:0] h);
        ring_slots[ring_tail] = h;
        ring_tail  = (ring_tail + 1) % CAPACITY;
        ring_count = ring_count + 1;
    endfunction

    function automatic void apply_queue_op(t_req r);
        logic                d;
        logic [HANDLE_W-1:0] dh;
        d  = 1'b0;
        dh = '0;
        case (r.func)
            FUNC_ENQ: begin
                if (r.key || ring_count < mark_reg) begin
                    if (ring_count >= CAPACITY) begin
                        dh = pop_oldest_slot();
                        d  = 1'b1;
                    end
                    push_newest_slot(r.handle);
                    drop_toggle = 1'b0;
                end else if (!drop_toggle) begin
                    d           = 1'b1;
                    dh          = r.handle;
                    drop_toggle = 1'b1;
                end else begin
                    if (ring_count > 0) begin
                        dh = pop_oldest_slot();
                        d  = 1'b1;
                    end
                    push_newest_slot(r.handle);
                    drop_toggle = 1'b0;
                end
                awaited_results.push_back(make_result(1'b0, '0, d, dh, 1'b1));
            end
            FUNC_DEQ: begin
                if (ring_count > 0) begin
                    dh = pop_oldest_slot();
                    awaited_results.push_back(make_result(1'b1, dh, 1'b0, '0, 1'b1));
                end else begin
                    awaited_results.push_back(make_result(1'b0, '0, 1'b0, '0, 1'b1));
                end
            end
            FUNC_CLEAR: begin
                if (ring_count == 0) begin
                    awaited_results.push_back(make_result(1'b0, '0, 1'b0, '0, 1'b1));
                end
                while (ring_count > 0) begin
                    dh = pop_oldest_slot();
                    awaited_results.push_back(make_result(1'b0, '0, 1'b1, dh,
                                                          ring_count == 0));
                end
                ring_head = 0;
                ring_tail = 0;
            end
            default: begin
                awaited_results.push_back(make_result(1'b0, '0, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            r.func = FUNC_ENQ;
        end else if (pick < 80) begin
            r.func = FUNC_DEQ;
        end else if (pick < 90) begin
            r.func = FUNC_CLEAR;
        end else begin
            r.func = FUNC_NOP;
        end
        case ($urandom_range(0, 7))
            0: r.handle = '0;
            1: r.handle = '1;
            default: r.handle = $urandom;
        endcase
        r.key = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    function automatic void flag_error(string what, t_res want, t_res seen);
        error_count++;
        if (error_count <= 10) begin
            $display("%s: expected ov=%0b oh=%h d=%0b dh=%h cnt=%0d last=%0b",
                     what, want.out_valid, want.out_handle, want.dropped,
                     want.dropped_handle, want.queue_count, want.last);
            $display("    actual   ov=%0b oh=%h d=%0b dh=%h cnt=%0d last=%0b",
                     seen.out_valid, seen.out_handle, seen.dropped,
                     seen.dropped_handle, seen.queue_count, seen.last);
        end
    endfunction

    task automatic add_step(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle,
                            logic key, int mark, bit typed, t_res want);
        t_plan_row row;
        row.req.func   = func;
        row.req.handle = handle;
        row.req.key    = key;
        row.mark       = mark;
        row.typed      = typed;
        row.want       = want;
        directed_plan.push_back(row);
    endtask

    task automatic send_request(t_req r);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid    <= 1'b1;
        i_func         <= r.func;
        i_frame_handle <= r.handle;
        i_is_key_frame <= r.key;
        do @(posedge i_clk); while (o_req_stall);
        apply_queue_op(r);
    endtask

    task automatic settle_queue();
        i_req_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mark(logic [HWM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MARK_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        mark_reg = value;
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_res seen;
        t_res want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            seen = {o_out_valid, o_out_handle, o_dropped, o_dropped_handle,
                    o_queue_count, o_last};
            if (awaited_results.size() == 0) begin
                flag_error("unexpected transfer", '0, seen);
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    flag_error("mismatch", want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : rsp_pacing
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_cycles > 0) begin
                wait_cycles      = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                wait_cycles = rsp_idle_on ? $urandom_range(0, 3) : 0;
            end
            if (wait_cycles > 0) begin
                i_rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_rsp_valid && !i_rsp_stall));
        end
    end

    initial begin : stimulus
        logic [HWM_W-1:0] next_mark;

        // reset mark of 3 applies until the first register write
        add_step(FUNC_DEQ,   32'h0000_0000, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd0, 1'b1});
        add_step(FUNC_CLEAR, 32'h0000_0000, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd0, 1'b1});
        add_step(FUNC_NOP,   32'hFFFF_FFFF, 1'b1, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd0, 1'b1});
        add_step(FUNC_ENQ,   32'h0000_0000, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd1, 1'b1});
        add_step(FUNC_ENQ,   32'hFFFF_FFFF, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd2, 1'b1});
        add_step(FUNC_ENQ,   32'h8000_0001, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd3, 1'b1});
        // at the mark: drop the new frame, then drop the oldest (handle zero)
        add_step(FUNC_ENQ,   32'h1234_5678, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b1, 32'h1234_5678, 5'd3, 1'b1});
        add_step(FUNC_ENQ,   32'hA5A5_A5A5, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b1, 32'h0, 5'd3, 1'b1});
        add_step(FUNC_ENQ,   32'h0000_0001, 1'b1, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd4, 1'b1});
        add_step(FUNC_ENQ,   32'h0000_0002, 1'b1, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd5, 1'b1});
        add_step(FUNC_ENQ,   32'h0000_0003, 1'b1, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 5'd5, 1'b1});
        add_step(FUNC_NOP,   32'h5555_AAAA, 1'b0, NO_MARK, 1'b1,
                 {1'b0, 32'h0, 1'b0, 32'h0, 5'd5, 1'b1});
        add_step(FUNC_DEQ,   32'h0000_0000, 1'b0, NO_MARK, 1'b1,
                 {1'b1, 32'h8000_0001, 1'b0, 32'h0, 5'd4, 1'b1});
        add_step(FUNC_ENQ,   32'h0000_0005, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_CLEAR, 32'h0000_0000, 1'b0, NO_MARK, 1'b0, '0);
        // mark of zero: toggle survives the clear, then the empty-queue case
        add_step(FUNC_ENQ,   32'h0000_0006, 1'b0, 0,       1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0007, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0008, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_DEQ,   32'h7FFF_FFFF, 1'b1, NO_MARK, 1'b0, '0);
        // mark above capacity: non-key frame at a full queue evicts the oldest
        add_step(FUNC_ENQ,   32'h0000_0010, 1'b0, 16,      1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0011, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0012, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0013, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0014, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_ENQ,   32'h0000_0015, 1'b0, NO_MARK, 1'b0, '0);
        add_step(FUNC_CLEAR, 32'h0000_0000, 1'b0, NO_MARK, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].mark != NO_MARK) begin
                settle_queue();
                write_mark(HWM_W'(directed_plan[i].mark));
            end
            send_request(directed_plan[i].req);
            if (directed_plan[i].typed) begin
                awaited_results[awaited_results.size() - 1] = directed_plan[i].want;
            end
        end

        for (int p = 0; p < 4; p++) begin
            settle_queue();
            case (p)
                0: begin
                    next_mark   = HWM_W'(CAPACITY);
                    req_idle_on = 1'b1;
                    rsp_idle_on = 1'b1;
                end
                1: begin
                    // hold the output long while requests keep coming
                    next_mark        = HWM_W'($urandom_range(0, 16));
                    req_idle_on      = 1'b0;
                    rsp_idle_on      = 1'b1;
                    long_hold_cycles = LONG_HOLD;
                end
                2: begin
                    next_mark   = HWM_W'($urandom_range(0, 4));
                    req_idle_on = 1'b0;
                    rsp_idle_on = 1'b0;
                end
                default: begin
                    next_mark   = HWM_W'($urandom_range(0, 16));
                    req_idle_on = 1'b1;
                    rsp_idle_on = 1'b1;
                end
            endcase
            write_mark(next_mark);
            repeat (RANDOM_PER_PHASE) send_request(random_request());
        end
        settle_queue();

        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
